/* rtl/front_middle_back_queue_core_defines.svh */
// ----------------------------------------------------------------------------
// Front-middle-back queue assertion macros
// Shared concurrent assertion forms for the queue core, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRONT_MIDDLE_BACK_QUEUE_CORE_DEFINES_SVH
`define FRONT_MIDDLE_BACK_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication.
`define FMBQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FMBQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fmbq_pkg.sv */
// ----------------------------------------------------------------------------
// Front-middle-back queue package
// Sizes, command and status codes, and the shift control word for the cells.
// ----------------------------------------------------------------------------
package fmbq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 32;
  localparam int OCC_W      = 7;
  localparam int CMD_W      = 3;
  localparam int STAT_W     = 2;
  localparam int POS_W      = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT  = 3'd0,
    CMD_PUSH_MIDDLE = 3'd1,
    CMD_PUSH_BACK   = 3'd2,
    CMD_POP_FRONT   = 3'd3,
    CMD_POP_MIDDLE  = 3'd4,
    CMD_POP_BACK    = 3'd5
  } fmbq_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } fmbq_stat_t;

  // Shift control broadcast to every cell: insert or remove at pos.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] pos;
  } fmbq_shift_t;

endpackage

/* rtl/front_middle_back_queue_core.sv */
// The result strobe on out_valid is registered: it follows an accepted command in the next cycle.
// Throughput: one command per cycle; busy stays low, so start may be held high.
// Each command shifts only the cells from its position upward, by at most one place.
// Reset (rst_n low, synchronous) empties the queue and clears out_valid.
// The receiver cannot stall: each result word is present for exactly one cycle.
// ----------------------------------------------------------------------------
// Front-middle-back queue core
// A bounded ordered queue of signed words with push and pop at the front,
// the middle and the back, built as a row of shifting cells.
// ----------------------------------------------------------------------------
`include "front_middle_back_queue_core_defines.svh"

module front_middle_back_queue_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [fmbq_pkg::CMD_W-1:0]    in_command,
  input  logic signed [fmbq_pkg::IN_W-1:0] in_push_value,
  output logic                          out_valid,
  output logic signed [fmbq_pkg::OUT_W-1:0] out_popped_value,
  output logic [fmbq_pkg::STAT_W-1:0]   out_status,
  output logic [fmbq_pkg::OCC_W-1:0]    out_occupancy
);
  import fmbq_pkg::*;

  // Position 0 of the row is the front of the queue. An insert at pos makes
  // every cell above pos take the word of its lower neighbor while the cell at
  // pos loads the pushed word; a remove at pos makes every cell at or above
  // pos take the word of its upper neighbor. Cells at or above the fill count
  // hold stale data that is never read.

  logic                  accept;
  logic [COUNT_W-1:0]    count_r;
  logic [COUNT_W-1:0]    count_nxt;
  fmbq_shift_t           shift;
  fmbq_stat_t            status;
  logic                  is_pop;
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  logic [DATA_WIDTH-1:0] pop_word;

  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_value_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [OCC_W-1:0]      out_occ_r;

  // Each successful command updates the row and fill count at the edge that takes it, so the core never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stored words keep the low DATA_WIDTH bits of the pushed word.
  assign push_word = in_push_value[DATA_WIDTH-1:0];

  fmbq_ctrl u_ctrl (
    .accept    (accept),
    .command   (in_command),
    .count     (count_r),
    .shift     (shift),
    .status    (status),
    .is_pop    (is_pop),
    .count_nxt (count_nxt)
  );

  // The row of cells. The first cell sees the pushed word past its edge, a path
  // that no legal shift selects; on a remove the last cell reloads its own word.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w;
    logic [DATA_WIDTH-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = push_word;
    end else begin : g_inner_prev
      assign prev_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = cell_word[i];
    end else begin : g_inner_next
      assign next_w = cell_word[i+1];
    end
    fmbq_cell u_cell (
      .clk       (clk),
      .cell_idx  (POS_W'(i)),
      .shift     (shift),
      .push_word (push_word),
      .prev_word (prev_w),
      .next_word (next_w),
      .word_q    (cell_word[i])
    );
  end

  // The word leaving the row is the one at the removal position, read before
  // the shift lands.
  assign pop_word = cell_word[shift.pos];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload; a popped word is sign-extended to the output width.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= is_pop ? OUT_W'($signed(pop_word)) : '0;
      out_status_r <= status;
      out_occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_occupancy    = out_occ_r;

  // The fill count never passes the depth of the row.
  `FMBQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= COUNT_W'(DEPTH), "fill count above depth")
  // Every accepted command gives exactly one result in the next cycle.
  `FMBQ_ASSERT_NEXT(a_one_result, 1'b1, out_valid == $past(accept), "result strobe mismatch")
  // A rejected or failed command leaves the fill count unchanged.
  `FMBQ_ASSERT_NOW(a_reject_hold, out_valid && (out_status != STAT_OK), out_occupancy == OCC_W'(count_r), "occupancy moved on reject")
  // A successful pop shrinks the queue by one.
  `FMBQ_ASSERT_NEXT(a_pop_count, accept && is_pop, count_r == $past(count_r) - COUNT_W'(1), "pop did not shrink queue")

endmodule

/* rtl/fmbq_cell.sv */
// ----------------------------------------------------------------------------
// Front-middle-back queue cell
// Holds one word; on a shift it takes a neighbor's word or the pushed word.
// ----------------------------------------------------------------------------
module fmbq_cell (
  input  logic                               clk,
  input  logic [fmbq_pkg::POS_W-1:0]         cell_idx,
  input  fmbq_pkg::fmbq_shift_t              shift,
  input  logic [fmbq_pkg::DATA_WIDTH-1:0]    push_word,
  input  logic [fmbq_pkg::DATA_WIDTH-1:0]    prev_word,
  input  logic [fmbq_pkg::DATA_WIDTH-1:0]    next_word,
  output logic [fmbq_pkg::DATA_WIDTH-1:0]    word_q
);
  import fmbq_pkg::*;

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (shift.ins) begin
      if (cell_idx > shift.pos) begin
        word_nxt = prev_word;
      end else if (cell_idx == shift.pos) begin
        word_nxt = push_word;
      end
    end else if (shift.rem) begin
      if (cell_idx >= shift.pos) begin
        word_nxt = next_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

/* rtl/fmbq_ctrl.sv */
// ----------------------------------------------------------------------------
// Front-middle-back queue command decoder
// Turns a command and the fill count into a shift, a status and a new count.
// ----------------------------------------------------------------------------
module fmbq_ctrl (
  input  logic                            accept,
  input  logic [fmbq_pkg::CMD_W-1:0]      command,
  input  logic [fmbq_pkg::COUNT_W-1:0]    count,
  output fmbq_pkg::fmbq_shift_t           shift,
  output fmbq_pkg::fmbq_stat_t            status,
  output logic                            is_pop,
  output logic [fmbq_pkg::COUNT_W-1:0]    count_nxt
);
  import fmbq_pkg::*;

  logic                full;
  logic                empty;
  logic [COUNT_W-1:0]  count_m1;

  assign full     = (count == COUNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign count_m1 = count - COUNT_W'(1);

  always_comb begin
    shift     = '0;
    status    = STAT_OK;
    is_pop    = 1'b0;
    count_nxt = count;
    unique case (fmbq_cmd_t'(command)) inside
      CMD_PUSH_FRONT, CMD_PUSH_MIDDLE, CMD_PUSH_BACK: begin
        if (full) begin
          status = STAT_FULL;
        end else begin
          shift.ins = accept;
          if (command == CMD_PUSH_FRONT) begin
            shift.pos = '0;
          end else if (command == CMD_PUSH_MIDDLE) begin
            shift.pos = count[POS_W:1];
          end else begin
            shift.pos = count[POS_W-1:0];
          end
          count_nxt = count + COUNT_W'(1);
        end
      end
      CMD_POP_FRONT, CMD_POP_MIDDLE, CMD_POP_BACK: begin
        if (empty) begin
          status = STAT_EMPTY;
        end else begin
          shift.rem = accept;
          is_pop    = 1'b1;
          if (command == CMD_POP_FRONT) begin
            shift.pos = '0;
          end else if (command == CMD_POP_MIDDLE) begin
            shift.pos = count_m1[POS_W:1];
          end else begin
            shift.pos = count_m1[POS_W-1:0];
          end
          count_nxt = count_m1;
        end
      end
      default: begin
        // Unused command codes leave the queue alone and report ok.
        status = STAT_OK;
      end
    endcase
  end

endmodule

/* test/tb_front_middle_back_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front-middle-back queue core testbench
// Sends queue commands through the start/busy handshake and predicts every
// result word with a behavioral queue kept in step with the block. Directed
// words cover the empty queue, middle placement and unused command codes.
// Random words, with sender gaps that change from phase to phase, fill the
// queue past full and drain it past empty.
// ----------------------------------------------------------------------------
module tb_front_middle_back_queue_core;
  import fmbq_pkg::*;

  // The command field is three bits wide, so two codes have no operation.
  // The block must treat them as a no-op that still returns a word.
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  // The watchdog counts cycles in which neither a command nor a result is
  // accepted. Sender gaps are random and each result follows its command in
  // the next cycle, so this limit is far above the slowest correct run.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to watch after the last expected word, for stray result strobes.
  localparam int DRAIN_CYCLES   = 4;

  typedef struct {
    logic signed [OUT_W-1:0] popped;
    fmbq_stat_t              status;
    logic [OCC_W-1:0]        occupancy;
  } queue_word_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         in_command;
  logic signed [IN_W-1:0]   in_push_value;
  logic                     out_valid;
  logic signed [OUT_W-1:0]  out_popped_value;
  logic [STAT_W-1:0]        out_status;
  logic [OCC_W-1:0]         out_occupancy;

  // Behavioral copy of the queue contents; index 0 is the front.
  logic [DATA_WIDTH-1:0] queue_contents[$];
  // Result words predicted at acceptance and not yet seen on the outputs.
  queue_word_t           pending_words[$];
  // Percentage of cycles in which the sender holds start low.
  int                    sender_gap_pct;
  int                    fail_count;
  int                    quiet_cycles;

  front_middle_back_queue_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy)
  );

  // 8 ns clock period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Apply one command to the queue copy and return the word the block must
  // answer with. Pushes store the low DATA_WIDTH bits, pops sign-extend the
  // removed entry to the output width. Pop middle takes the frontmost of the
  // two middle entries, push middle lands at half the current count.
  function automatic queue_word_t predict_queue_word(logic [CMD_W-1:0] cmd,
                                                     logic signed [IN_W-1:0] value);
    queue_word_t      word;
    int unsigned      count;
    int unsigned      pos;
    logic [DATA_WIDTH-1:0] entry;
    count       = queue_contents.size();
    word.popped = '0;
    word.status = STAT_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_MIDDLE, CMD_PUSH_BACK: begin
        if (count >= DEPTH) begin
          // The push is rejected and the queue stays as it is.
          word.status = STAT_FULL;
        end else if (cmd == CMD_PUSH_FRONT) begin
          queue_contents.insert(0, value[DATA_WIDTH-1:0]);
        end else if (cmd == CMD_PUSH_MIDDLE) begin
          queue_contents.insert(count / 2, value[DATA_WIDTH-1:0]);
        end else begin
          queue_contents.insert(count, value[DATA_WIDTH-1:0]);
        end
      end
      CMD_POP_FRONT, CMD_POP_MIDDLE, CMD_POP_BACK: begin
        if (count == 0) begin
          word.status = STAT_EMPTY;
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            pos = 0;
          end else if (cmd == CMD_POP_MIDDLE) begin
            pos = (count - 1) / 2;
          end else begin
            pos = count - 1;
          end
          entry = queue_contents[pos];
          queue_contents.delete(pos);
          word.popped = OUT_W'($signed(entry));
        end
      end
      default: begin
        // Unused codes leave the queue untouched and report ok.
      end
    endcase
    word.occupancy = OCC_W'(queue_contents.size());
    return word;
  endfunction

  // Send one command word. In each cycle the sender idles with the current
  // gap percentage, holding start low for that cycle. Start is raised at a
  // falling edge and is left high afterwards, so back-to-back words see no
  // gap at all. The prediction is made at the rising edge where start is
  // high and busy low.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [IN_W-1:0] value);
    queue_word_t want;
    while ($urandom_range(99) < sender_gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start         <= 1'b1;
    in_command    <= cmd;
    in_push_value <= value;
    do begin
      @(posedge clk);
    end while (busy);
    want = predict_queue_word(cmd, value);
    pending_words.insert(pending_words.size(), want);
  endtask

  // Mostly uniform words, with the sign boundary and all-ones/all-zeros
  // patterns mixed in often enough to reach the storage extremes.
  function automatic logic signed [IN_W-1:0] pick_push_value();
    case ($urandom_range(11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(int push_pct);
    if ($urandom_range(99) < 3) begin
      return $urandom_range(1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
    end else if ($urandom_range(99) < push_pct) begin
      return CMD_W'($urandom_range(CMD_PUSH_BACK, CMD_PUSH_FRONT));
    end else begin
      return CMD_W'($urandom_range(CMD_POP_BACK, CMD_POP_FRONT));
    end
  endfunction

  // All three pops on an empty queue after reset must report empty and
  // ignore the push value.
  task automatic test_pops_on_empty();
    send_command(CMD_POP_FRONT, -32'sd1);
    send_command(CMD_POP_MIDDLE, 32'sh8000_0000);
    send_command(CMD_POP_BACK, 32'sh7FFF_FFFF);
  endtask

  // Builds a short queue by hand so the middle placements can be seen:
  // with an even count pop middle must take the frontmost middle entry, and
  // push middle must land at half the count. Extreme values travel through.
  task automatic test_middle_positions();
    send_command(CMD_PUSH_BACK, 32'sd1);
    send_command(CMD_PUSH_BACK, 32'sd2);
    send_command(CMD_PUSH_BACK, 32'sd3);
    send_command(CMD_PUSH_BACK, 32'sd4);
    send_command(CMD_PUSH_MIDDLE, 32'sh7FFF_FFFF);
    send_command(CMD_PUSH_FRONT, 32'sh8000_0000);
    send_command(CMD_POP_MIDDLE, 32'sd0);
    send_command(CMD_POP_MIDDLE, 32'sd0);
    send_command(CMD_PUSH_MIDDLE, -32'sd1);
    send_command(CMD_PUSH_MIDDLE, 32'sd0);
    send_command(CMD_POP_FRONT, 32'sd0);
    send_command(CMD_POP_BACK, 32'sd0);
    send_command(CMD_POP_MIDDLE, 32'sd0);
    send_command(CMD_POP_MIDDLE, 32'sd0);
    send_command(CMD_POP_MIDDLE, 32'sd0);
    send_command(CMD_POP_MIDDLE, 32'sd0);
  endtask

  // Unused codes carry a push value but must not change the queue.
  task automatic test_unused_commands();
    send_command(CMD_PUSH_BACK, 32'sh5A5A_A5A5);
    send_command(CMD_UNUSED_6, -32'sd1);
    send_command(CMD_UNUSED_7, 32'sh8000_0000);
    send_command(CMD_POP_BACK, 32'sd0);
  endtask

  // Fills the queue to DEPTH with random pushes, then pushes twice more to
  // see the full rejection, then pops down past empty.
  task automatic test_fill_and_drain();
    while (queue_contents.size() < DEPTH) begin
      send_command(CMD_W'($urandom_range(CMD_PUSH_BACK, CMD_PUSH_FRONT)),
                   pick_push_value());
    end
    repeat (2) send_command(CMD_W'($urandom_range(CMD_PUSH_BACK, CMD_PUSH_FRONT)),
                            pick_push_value());
    while (queue_contents.size() > 0) begin
      send_command(CMD_W'($urandom_range(CMD_POP_BACK, CMD_POP_FRONT)),
                   pick_push_value());
    end
    repeat (2) send_command(CMD_W'($urandom_range(CMD_POP_BACK, CMD_POP_FRONT)),
                            pick_push_value());
  endtask

  // Random commands in bursts of 100. Each burst draws its own push bias, so
  // the occupancy drifts between empty and full.
  task automatic test_random_traffic(int num_words);
    int push_pct;
    for (int i = 0; i < num_words; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(3))
          0:       push_pct = 15;
          1:       push_pct = 50;
          2:       push_pct = 85;
          default: push_pct = 95;
        endcase
      end
      send_command(pick_command(push_pct), pick_push_value());
    end
  endtask

  // Result checker. Every strobed word is compared against the oldest
  // prediction; outputs are read at the rising edge before the block updates.
  always @(posedge clk) begin : check_results
    queue_word_t want;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $error("result word with no command outstanding: popped %0d status %0d occ %0d",
               out_popped_value, out_status, out_occupancy);
        fail_count++;
      end else begin
        want = pending_words[0];
        pending_words.delete(0);
        if (out_popped_value !== want.popped) begin
          $error("out_popped_value mismatch: expected %0d, actual %0d",
                 want.popped, out_popped_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("out_status mismatch: expected %0d, actual %0d",
                 want.status, out_status);
          fail_count++;
        end
        if (out_occupancy !== want.occupancy) begin
          $error("out_occupancy mismatch: expected %0d, actual %0d",
                 want.occupancy, out_occupancy);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any accepted command or result word restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_command     = '0;
    in_push_value  = '0;
    sender_gap_pct = 0;

    // Synchronous reset held low from the start, released at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words, sent back to back.
    test_pops_on_empty();
    test_middle_positions();
    test_unused_commands();

    // Random traffic: first with the sender idle in about one cycle of five,
    // then idle in most cycles, then with no gaps at all.
    sender_gap_pct = 21;
    test_fill_and_drain();
    test_random_traffic(550);
    sender_gap_pct = 84;
    test_random_traffic(550);
    sender_gap_pct = 0;
    test_random_traffic(550);
    test_fill_and_drain();

    @(negedge clk);
    start <= 1'b0;

    // Wait for the last predicted word, then keep watching for any stray
    // strobe. A hang here is caught by the watchdog.
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/fmbq_pkg.sv
rtl/fmbq_cell.sv
rtl/fmbq_ctrl.sv
rtl/front_middle_back_queue_core.sv
test/tb_front_middle_back_queue_core.sv
